>>> rtl/core/sorted_timeout_queue_macros.svh
// ----------------------------------------------------------------------------
// sorted timeout queue assertion macros
// shared property forms for same-cycle and next-cycle implications
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMEOUT_QUEUE_MACROS_SVH
`define SORTED_TIMEOUT_QUEUE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define STQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sto_pkg.sv
// ----------------------------------------------------------------------------
// sto_pkg
// shared widths, request codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package sto_pkg;

    localparam int DEFAULT_SLOTS = 16;

    localparam int KIND_W     = 2;
    localparam int HANDLE_W   = 16;
    localparam int DUR_W      = 31;
    localparam int DEADLINE_W = 48;
    localparam int US_PER_MS  = 1000;
    // 31-bit milliseconds times 1000 fits in 41 bits
    localparam int PROD_W     = 41;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;

    // read address select for the table
    typedef enum logic [1:0] {
        RD_FRONT  = 2'd0,
        RD_IDX    = 2'd1,
        RD_IDX_M1 = 2'd2,
        RD_IDX_M2 = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    set_drop;
        logic    mul;
        logic    sum;
        rd_sel_t rd_sel;
        logic    shift;
        logic    place;
        logic    set_rearm;
        logic    delay_from_ram;
        logic    cmp_start;
        logic    idx_inc;
        logic    cmp_step;
        logic    cmp_last;
        logic    out_load;
    } sto_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              count_zero;
        logic              count_full;
        logic              idx_zero;
        logic              idx_one;
        logic              idx_at_count;
        logic              later;
    } sto_status_t;

endpackage

>>> rtl/core/sto_ram.sv
// ----------------------------------------------------------------------------
// sto_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sto_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sto_ctrl.sv
// ----------------------------------------------------------------------------
// sto_ctrl
// request sequencer: decode, insert scan, compaction and result handoff
// ----------------------------------------------------------------------------
`include "sorted_timeout_queue_macros.svh"

module sto_ctrl import sto_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  sto_status_t status,
    output sto_cmd_t    cmd
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_DISPATCH  = 12'b0000_0000_0010,
        ST_MUL       = 12'b0000_0000_0100,
        ST_SUM       = 12'b0000_0000_1000,
        ST_PRIME     = 12'b0000_0001_0000,
        ST_SCAN      = 12'b0000_0010_0000,
        ST_PLACE     = 12'b0000_0100_0000,
        ST_FRONT_RD  = 12'b0000_1000_0000,
        ST_FRONT_USE = 12'b0001_0000_0000,
        ST_CMP_PRIME = 12'b0010_0000_0000,
        ST_CMP       = 12'b0100_0000_0000,
        ST_FINISH    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_FRONT;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.kind)
                    KIND_ADD: begin
                        if (status.count_full) begin
                            cmd.set_drop = 1'b1;
                            state_next   = ST_FINISH;
                        end else begin
                            state_next = ST_MUL;
                        end
                    end
                    KIND_REMOVE: begin
                        cmd.cmp_start = 1'b1;
                        state_next    = status.count_zero ? ST_FINISH : ST_CMP_PRIME;
                    end
                    KIND_FIRE: begin
                        state_next = status.count_zero ? ST_FINISH : ST_FRONT_RD;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_PRIME;
            end
            ST_PRIME: begin
                cmd.rd_sel = RD_IDX_M1;
                state_next = status.idx_zero ? ST_PLACE : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.rd_sel = RD_IDX_M2;
                if (status.later) begin
                    cmd.shift  = 1'b1;
                    state_next = status.idx_one ? ST_PLACE : ST_SCAN;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.place     = 1'b1;
                cmd.set_rearm = status.idx_zero;
                state_next    = ST_FINISH;
            end
            ST_FRONT_RD: begin
                cmd.rd_sel = RD_FRONT;
                state_next = ST_FRONT_USE;
            end
            ST_FRONT_USE: begin
                cmd.set_rearm      = 1'b1;
                cmd.delay_from_ram = 1'b1;
                state_next         = ST_FINISH;
            end
            ST_CMP_PRIME: begin
                cmd.rd_sel  = RD_IDX;
                cmd.idx_inc = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                cmd.rd_sel   = RD_IDX;
                cmd.idx_inc  = 1'b1;
                cmd.cmp_step = 1'b1;
                if (status.idx_at_count) begin
                    cmd.cmp_last = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `STQ_ASSERT_NEXT(a_accept_dispatch, aclk, aresetn, s_valid && s_ready, state_reg == ST_DISPATCH, "accepted request did not move to dispatch")
    `STQ_ASSERT_NEXT(a_finish_holds, aclk, aresetn, (state_reg == ST_FINISH) && m_valid_reg && !m_ready, (state_reg == ST_FINISH) && m_valid_reg, "result overwritten while output stalled")
    `STQ_ASSERT_SAME(a_place_not_full, aclk, aresetn, cmd.place, !status.count_full, "insert issued on a full table")
    `STQ_ASSERT_SAME(a_scan_idx_nonzero, aclk, aresetn, state_reg == ST_SCAN, !status.idx_zero, "insert scan running past the table front")

endmodule

>>> rtl/core/sto_datapath.sv
// ----------------------------------------------------------------------------
// sto_datapath
// request registers, deadline arithmetic, sorted table and result registers
// ----------------------------------------------------------------------------
module sto_datapath import sto_pkg::*; #(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [HANDLE_W-1:0]   s_handle,
    input  logic [DUR_W-1:0]      s_duration_ms,
    input  logic [DEADLINE_W-1:0] s_now_us,
    input  sto_cmd_t              cmd,
    output sto_status_t           status,
    output logic                  m_rearm,
    output logic [DEADLINE_W-1:0] m_delay_us,
    output logic                  m_queue_empty,
    output logic                  m_dropped
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = DEADLINE_W + HANDLE_W;

    logic [KIND_W-1:0]     kind_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [DUR_W-1:0]      dur_reg;
    logic [DEADLINE_W-1:0] now_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DEADLINE_W-1:0] dl_reg;
    logic                  rearm_reg;
    logic [DEADLINE_W-1:0] delay_reg;
    logic                  dropped_reg;
    logic                  m_rearm_reg;
    logic [DEADLINE_W-1:0] m_delay_us_reg;
    logic                  m_queue_empty_reg;
    logic                  m_dropped_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_j_reg, wr_j_next;
    logic [CW-1:0] j_after;

    logic [DEADLINE_W:0]   sum_full;
    logic [DEADLINE_W-1:0] front;
    logic [DEADLINE_W-1:0] delay_calc;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [EW-1:0] ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_data;

    logic [DEADLINE_W-1:0] rd_deadline;
    logic [HANDLE_W-1:0]   rd_owner;
    logic                  keep;

    assign rd_deadline = ram_rd_data[EW-1 -: DEADLINE_W];
    assign rd_owner    = ram_rd_data[HANDLE_W-1:0];
    assign keep        = (rd_owner != handle_reg);

    // deadline sum with saturation at the top of the 48-bit range
    assign sum_full = {1'b0, now_reg} + {{(DEADLINE_W + 1 - PROD_W){1'b0}}, prod_reg};

    assign front      = cmd.delay_from_ram ? rd_deadline : dl_reg;
    assign delay_calc = (front > now_reg) ? (front - now_reg) : '0;

    assign j_after = (cmd.cmp_step && keep) ? (wr_j_reg + CW'(1)) : wr_j_reg;

    always_comb begin
        case (cmd.rd_sel)
            RD_FRONT:  ram_rd_addr = '0;
            RD_IDX:    ram_rd_addr = idx_reg[AW-1:0];
            RD_IDX_M1: ram_rd_addr = AW'(idx_reg - CW'(1));
            RD_IDX_M2: ram_rd_addr = AW'(idx_reg - CW'(2));
            default:   ram_rd_addr = '0;
        endcase
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg[AW-1:0];
        ram_wr_data = ram_rd_data;
        if (cmd.shift) begin
            ram_wr_en = 1'b1;
        end
        if (cmd.place) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {dl_reg, handle_reg};
        end
        if (cmd.cmp_step && keep) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_j_reg[AW-1:0];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.place) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cmp_last) begin
            count_next = j_after;
        end

        idx_next = idx_reg;
        if (cmd.sum) begin
            idx_next = count_reg;
        end else if (cmd.shift) begin
            idx_next = idx_reg - CW'(1);
        end else if (cmd.cmp_start) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CW'(1);
        end

        wr_j_next = wr_j_reg;
        if (cmd.cmp_start) begin
            wr_j_next = '0;
        end else if (cmd.cmp_step) begin
            wr_j_next = j_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            wr_j_reg  <= '0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            wr_j_reg  <= wr_j_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_kind;
            handle_reg  <= s_handle;
            dur_reg     <= s_duration_ms;
            now_reg     <= s_now_us;
            rearm_reg   <= 1'b0;
            delay_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(dur_reg) * PROD_W'(US_PER_MS);
        end
        if (cmd.sum) begin
            dl_reg <= sum_full[DEADLINE_W] ? '1 : sum_full[DEADLINE_W-1:0];
        end
        if (cmd.set_drop) begin
            dropped_reg <= 1'b1;
        end
        if (cmd.set_rearm) begin
            rearm_reg <= 1'b1;
            delay_reg <= delay_calc;
        end
        if (cmd.out_load) begin
            m_rearm_reg       <= rearm_reg;
            m_delay_us_reg    <= delay_reg;
            m_queue_empty_reg <= (count_reg == '0);
            m_dropped_reg     <= dropped_reg;
        end
    end

    sto_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign status.kind         = kind_reg;
    assign status.count_zero   = (count_reg == '0);
    assign status.count_full   = (count_reg == CW'(SLOTS));
    assign status.idx_zero     = (idx_reg == '0);
    assign status.idx_one      = (idx_reg == CW'(1));
    assign status.idx_at_count = (idx_reg == count_reg);
    assign status.later        = (rd_deadline > dl_reg);

    assign m_rearm       = m_rearm_reg;
    assign m_delay_us    = m_delay_us_reg;
    assign m_queue_empty = m_queue_empty_reg;
    assign m_dropped     = m_dropped_reg;

endmodule

>>> rtl/core/sorted_timeout_queue.sv
// dropped adds, unused codes, fire or remove on an empty table go straight from
// dispatch to the finish step
// throughput: one request at a time, the next taken in the cycle after the result loads;
//   an unread result holds the finish step; the table's single read port sets the scan rate
// reset: synchronous active-low aresetn empties the table count and idles the sequencer
// ----------------------------------------------------------------------------
// sorted_timeout_queue
// deadline-sorted timeout table with re-arm delay computation
// ----------------------------------------------------------------------------
module sorted_timeout_queue import sto_pkg::*; #(
    // number of timeout entries held in the table
    parameter int TIMER_SLOTS = DEFAULT_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [HANDLE_W-1:0]   s_handle,
    input  logic [DUR_W-1:0]      s_duration_ms,
    input  logic [DEADLINE_W-1:0] s_now_us,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_rearm,
    output logic [DEADLINE_W-1:0] m_delay_us,
    output logic                  m_queue_empty,
    output logic                  m_dropped
);

    // the controller only sees compact status flags and drives command
    // strobes; all storage and arithmetic live in the datapath
    sto_cmd_t    cmd;
    sto_status_t status;

    // sequencer: one request in flight
    //   add    -> multiply ms by 1000, add now with saturation, then walk
    //             from the tail toward the front moving later deadlines up
    //             one slot, and drop the new entry into the hole
    //   remove -> stream every entry through once, writing back only
    //             entries owned by another handle
    //   fire   -> read the front deadline and compute the delay
    // the finish step waits only if the previous result is still unread
    sto_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: request capture, deadline math, sorted table in ram,
    // and the output register that decouples the result channel
    sto_datapath #(
        .SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_handle      (s_handle),
        .s_duration_ms (s_duration_ms),
        .s_now_us      (s_now_us),
        .cmd           (cmd),
        .status        (status),
        .m_rearm       (m_rearm),
        .m_delay_us    (m_delay_us),
        .m_queue_empty (m_queue_empty),
        .m_dropped     (m_dropped)
    );

endmodule

>>> verif/tb_sorted_timeout_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timeout_queue
// self-checking bench for the deadline-sorted timeout table: a local table
// model predicts every result, randomized traffic with idle gaps and
// back-pressure on both channels, directed cases for ordering and corners
// ----------------------------------------------------------------------------
module tb_sorted_timeout_queue;
    import sto_pkg::*;

    localparam int SLOTS = DEFAULT_SLOTS;
    // the 2-bit kind field has one code the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [DEADLINE_W-1:0] TIME_MAX = '1;

    localparam int IDLE_PERCENT    = 31;
    localparam int REPORT_LIMIT    = 10;
    localparam int BURST_REQUESTS  = 300;
    localparam int RANDOM_REQUESTS = 1300;
    // sized so the worst remove, a scan of the full table, fits with margin
    localparam int SETTLE_CYCLES   = 2 * SLOTS + 16;
    // ~1650 requests of work plus stalls on both sides
    localparam int CYCLE_LIMIT     = 600000;

    typedef struct packed {
        logic                  rearm;
        logic [DEADLINE_W-1:0] delay_us;
        logic                  queue_empty;
        logic                  dropped;
    } timer_result_t;

    // clock, reset and all block inputs start at known values
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_kind        = KIND_FIRE;
    logic [HANDLE_W-1:0]   s_handle      = '0;
    logic [DUR_W-1:0]      s_duration_ms = '0;
    logic [DEADLINE_W-1:0] s_now_us      = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_rearm;
    logic [DEADLINE_W-1:0] m_delay_us;
    logic                  m_queue_empty;
    logic                  m_dropped;

    sorted_timeout_queue #(
        .TIMER_SLOTS(SLOTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_handle      (s_handle),
        .s_duration_ms (s_duration_ms),
        .s_now_us      (s_now_us),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rearm       (m_rearm),
        .m_delay_us    (m_delay_us),
        .m_queue_empty (m_queue_empty),
        .m_dropped     (m_dropped)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // timeout table model: sorted deadlines with their owners
    // ------------------------------------------------------------------------
    logic [DEADLINE_W-1:0] table_deadline [SLOTS];
    logic [HANDLE_W-1:0]   table_owner    [SLOTS];
    int                    table_count = 0;

    timer_result_t         expected_results [$];

    // bench bookkeeping
    bit                    no_idle        = 1'b0;
    logic [DEADLINE_W-1:0] now_clock      = '0;
    int                    failures       = 0;
    int                    requests_sent  = 0;
    int                    results_seen   = 0;
    int                    rearms_seen    = 0;
    int                    drops_seen     = 0;
    int                    cycle_count    = 0;

    // delay to the front deadline, zero once it has passed
    function automatic logic [DEADLINE_W-1:0] front_delay(input logic [DEADLINE_W-1:0] now);
        return (table_deadline[0] > now) ? table_deadline[0] - now : '0;
    endfunction

    // applies one request to the table model and returns its result
    function automatic timer_result_t apply_timer_request(
        input logic [KIND_W-1:0]     kind,
        input logic [HANDLE_W-1:0]   handle,
        input logic [DUR_W-1:0]      dur,
        input logic [DEADLINE_W-1:0] now
    );
        timer_result_t         res;
        logic [PROD_W-1:0]     prod;
        logic [DEADLINE_W:0]   sum;
        logic [DEADLINE_W-1:0] deadline;
        int                    pos;
        int                    idx;
        int                    keep;
        res = '0;
        case (kind)
            KIND_ADD: begin
                if (table_count >= SLOTS) begin
                    res.dropped = 1'b1;
                end else begin
                    prod = {{(PROD_W - DUR_W){1'b0}}, dur} * PROD_W'(US_PER_MS);
                    sum  = {1'b0, now} + {{(DEADLINE_W + 1 - PROD_W){1'b0}}, prod};
                    // deadline past the end of the time range sticks at the top
                    deadline = sum[DEADLINE_W] ? TIME_MAX : sum[DEADLINE_W-1:0];
                    // new entry goes behind every equal or earlier deadline
                    pos = 0;
                    while (pos < table_count && table_deadline[pos] <= deadline)
                        pos++;
                    for (idx = table_count; idx > pos; idx--) begin
                        table_deadline[idx] = table_deadline[idx-1];
                        table_owner[idx]    = table_owner[idx-1];
                    end
                    table_deadline[pos] = deadline;
                    table_owner[pos]    = handle;
                    table_count++;
                    if (pos == 0) begin
                        res.rearm    = 1'b1;
                        res.delay_us = front_delay(now);
                    end
                end
            end
            KIND_REMOVE: begin
                keep = 0;
                for (idx = 0; idx < table_count; idx++) begin
                    if (table_owner[idx] != handle) begin
                        table_deadline[keep] = table_deadline[idx];
                        table_owner[keep]    = table_owner[idx];
                        keep++;
                    end
                end
                table_count = keep;
            end
            KIND_FIRE: begin
                if (table_count > 0) begin
                    res.rearm    = 1'b1;
                    res.delay_us = front_delay(now);
                end
            end
            default: begin
                // unused code: table untouched, nothing raised
            end
        endcase
        res.queue_empty = (table_count == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // sends one request; valid drops only when an idle gap is taken, so a
    // back-to-back request keeps valid high without a second assignment
    task automatic send_request(
        input logic [KIND_W-1:0]     kind,
        input logic [HANDLE_W-1:0]   handle,
        input logic [DUR_W-1:0]      dur,
        input logic [DEADLINE_W-1:0] now
    );
        bit lowered;
        lowered = 1'b0;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            if (!lowered)
                s_valid <= 1'b0;
            lowered = 1'b1;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_handle      <= handle;
        s_duration_ms <= dur;
        s_now_us      <= now;
        expected_results.insert(expected_results.size(),
                                apply_timer_request(kind, handle, dur, now));
        requests_sent++;
        // accepted at the first edge with ready high
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender holds off until every outstanding result has been returned
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // random request shaped around a small handle pool so removes hit and
    // the table keeps filling up; time mostly moves forward in small steps
    task automatic send_random_request();
        int unsigned         pick;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [DUR_W-1:0]    dur;
        pick = $urandom_range(99);
        if (pick < 45)
            kind = KIND_ADD;
        else if (pick < 65)
            kind = KIND_REMOVE;
        else if (pick < 94)
            kind = KIND_FIRE;
        else
            kind = KIND_UNUSED;

        pick = $urandom_range(99);
        if (pick < 40)
            handle = HANDLE_W'($urandom_range(7));
        else if (pick < 75)
            handle = 16'hFFF8 | HANDLE_W'($urandom_range(7));
        else
            handle = HANDLE_W'($urandom);

        pick = $urandom_range(99);
        if (pick < 55)
            dur = DUR_W'($urandom_range(20));
        else if (pick < 85)
            dur = DUR_W'($urandom_range(3000));
        else if (pick < 95)
            dur = DUR_W'($urandom);
        else
            dur = '1;

        pick = $urandom_range(99);
        if (pick < 80)
            now_clock = now_clock + DEADLINE_W'($urandom_range(8000));
        else if (pick < 88)
            // time steps back: front deadlines look further away
            now_clock = now_clock - DEADLINE_W'($urandom_range(40000));
        else if (pick < 95)
            now_clock = DEADLINE_W'({$urandom, $urandom});
        else
            // near the top of the range so adds saturate
            now_clock = TIME_MAX - DEADLINE_W'($urandom_range(5000000));

        send_request(kind, handle, dur, now_clock);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // fire, unused code and remove with nothing stored
    task automatic test_empty_table();
        send_request(KIND_FIRE, 16'h0000, '0, '0);
        send_request(KIND_UNUSED, 16'h0001, 31'd7, 48'd12345);
        send_request(KIND_REMOVE, 16'h1234, '0, 48'd100);
    endtask

    // front insertion, equal deadlines kept in arrival order, remove, past deadline
    task automatic test_deadline_order();
        logic [DEADLINE_W-1:0] base;
        base = 48'd1000000;
        send_request(KIND_ADD, 16'd1, 31'd5, base);
        send_request(KIND_ADD, 16'd2, 31'd5, base);           // equal deadline, no rearm
        send_request(KIND_ADD, 16'd3, 31'd2, base + 100);     // new front
        send_request(KIND_ADD, 16'd4, 31'd0, base + 200);     // deadline equals now
        send_request(KIND_REMOVE, 16'd4, '0, base + 250);
        send_request(KIND_REMOVE, 16'd3, '0, base + 260);
        send_request(KIND_FIRE, 16'd0, '0, base + 300);
        send_request(KIND_REMOVE, 16'd1, '0, base + 400);
        send_request(KIND_FIRE, 16'd0, '0, base + 9000);      // front already passed
    endtask

    // widest fields: deadline overflow, zero time, extreme handles
    task automatic test_field_extremes();
        send_request(KIND_ADD, 16'hFFFF, '1, TIME_MAX);       // saturates at top
        send_request(KIND_ADD, 16'h0000, '1, '0);
        send_request(KIND_FIRE, 16'hFFFF, '0, '0);
        send_request(KIND_REMOVE, 16'hFFFF, '1, TIME_MAX);
    endtask

    // fill every slot, one add too many, then clear and let it all drain
    task automatic test_full_table();
        while (table_count < SLOTS)
            send_request(KIND_ADD, 16'hA5A5, DUR_W'($urandom_range(100)), 48'd2000000);
        send_request(KIND_ADD, 16'h5A5A, 31'd1, 48'd2000000);
        send_request(KIND_REMOVE, 16'hA5A5, '0, 48'd2000001);
        wait_for_drain();
    endtask

    // long stretch with neither side idling
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count) send_random_request();
        no_idle = 1'b0;
    endtask

    // random traffic with idling on both sides, one full drain midway
    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_random_request();
            if (n == count / 2)
                wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: checks each accepted result, then picks next ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        timer_result_t got;
        timer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_rearm, m_delay_us, m_queue_empty, m_dropped};
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result rearm=%0b delay=%0d empty=%0b dropped=%0b",
                             got.rearm, got.delay_us, got.queue_empty, got.dropped);
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                if (got.rearm)
                    rearms_seen++;
                if (got.dropped)
                    drops_seen++;
                if (got.rearm !== want.rearm || got.delay_us !== want.delay_us ||
                    got.queue_empty !== want.queue_empty || got.dropped !== want.dropped) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display({"result %0d mismatch: expected rearm=%0b delay=%0d ",
                                  "empty=%0b dropped=%0b, got rearm=%0b delay=%0d ",
                                  "empty=%0b dropped=%0b"},
                                 results_seen, want.rearm, want.delay_us,
                                 want.queue_empty, want.dropped, got.rearm,
                                 got.delay_us, got.queue_empty, got.dropped);
                end
            end
        end
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("sorted_timeout_queue test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_deadline_order();
        test_field_extremes();
        test_full_table();
        test_back_to_back(BURST_REQUESTS);
        test_random_traffic(RANDOM_REQUESTS);

        // everything accepted: wait out the last results and a quiet tail
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests: ordering, saturation, full table, empty-table cases",
                 requests_sent);
        $display("checked %0d results (%0d re-arms, %0d dropped adds), %0d failures",
                 results_seen, rearms_seen, drops_seen, failures);
        if (failures == 0)
            $display("sorted_timeout_queue test passed");
        else
            $display("sorted_timeout_queue test failed");
        $finish;
    end

endmodule
